// File: hdl/midpoint_circle_rasterizer_unit_assert.svh
// assertion macros shared by the circle rasterizer modules
// no dependencies; included inside module bodies
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_ASSERT_SVH

// property checked while out of reset
`define MCR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge
`define MCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mcr_pkg.sv
// shared widths, codes and types of the circle rasterizer
// no dependencies
package mcr_pkg;

    localparam int RADIUS_BITS  = 10;
    localparam int COORD_BITS   = 11;
    localparam int STEP_BITS    = RADIUS_BITS + 1;
    localparam int PIXEL_BITS   = 13;
    localparam int DEC_BITS     = 16;
    localparam int ORIGIN_BITS  = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int PIX_PER_STEP = 8;
    localparam int PIX_IDX_BITS = $clog2(PIX_PER_STEP);

    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = CFG_IDX_BITS'(1);

    localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET = ORIGIN_BITS'(320);
    localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET = ORIGIN_BITS'(240);

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    // one octant point handed from front to back
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [STEP_BITS-1:0]  x;
        logic signed [STEP_BITS-1:0]  y;
        logic                         done;
    } t_step;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/mcr_in_if.sv
// command channel of the circle rasterizer
// depends on mcr_pkg
interface mcr_in_if;
    import mcr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius;

    modport source (output valid, action, center_x, center_y, radius, input ready);
    modport sink   (input valid, action, center_x, center_y, radius, output ready);
endinterface

// File: hdl/mcr_out_if.sv
// pixel channel of the circle rasterizer
// depends on mcr_pkg
interface mcr_out_if;
    import mcr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_x;
    logic signed [PIXEL_BITS-1:0] pixel_y;
    logic                         last_of_step;
    logic                         circle_done;

    modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

// File: hdl/mcr_front.sv
// front end: takes commands, keeps circle state, pushes octant points
// depends on mcr_pkg, mcr_in_if
module mcr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcr_in_if.sink        i_cmd,
    input  logic          i_q_full,
    output logic          o_push,
    output mcr_pkg::t_step o_entry
);
    import mcr_pkg::*;

    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic signed [STEP_BITS-1:0]  r_x;
    logic signed [STEP_BITS-1:0]  r_y;
    logic signed [DEC_BITS-1:0]   r_dec;

    logic                         n_active;
    logic signed [COORD_BITS-1:0] n_cx;
    logic signed [COORD_BITS-1:0] n_cy;
    logic signed [STEP_BITS-1:0]  n_x;
    logic signed [STEP_BITS-1:0]  n_y;
    logic signed [DEC_BITS-1:0]   n_dec;

    logic                         accept;
    logic                         live;
    logic signed [STEP_BITS-1:0]  upd_x;
    logic signed [STEP_BITS-1:0]  upd_y;
    logic signed [DEC_BITS-1:0]   upd_dec;
    logic signed [DEC_BITS-1:0]   x_ext;
    logic signed [DEC_BITS-1:0]   diff;
    logic                         upd_done;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && !i_q_full;
    assign live        = r_active && !(r_x > r_y);

    always_comb begin
        x_ext = DEC_BITS'(r_x);
        diff  = DEC_BITS'(r_x) - DEC_BITS'(r_y);
        upd_x = r_x + STEP_BITS'(1);
        if (r_dec[DEC_BITS-1]) begin
            upd_dec = r_dec + {x_ext[DEC_BITS-3:0], 2'b00} + DEC_BITS'(6);
            upd_y   = r_y;
        end else begin
            upd_dec = r_dec + {diff[DEC_BITS-3:0], 2'b00} + DEC_BITS'(10);
            upd_y   = r_y - STEP_BITS'(1);
        end
        upd_done = upd_x > upd_y;
    end

    always_comb begin
        n_active = r_active;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_dec    = r_dec;
        o_push   = 1'b0;
        if (accept) begin
            if (i_cmd.action == ACTION_START) begin
                n_active = 1'b1;
                n_cx     = i_cmd.center_x;
                n_cy     = i_cmd.center_y;
                n_x      = '0;
                n_y      = $signed(STEP_BITS'(i_cmd.radius));
                n_dec    = DEC_BITS'(3) - (DEC_BITS'(i_cmd.radius) << 1);
            end else if (live) begin
                n_x      = upd_x;
                n_y      = upd_y;
                n_dec    = upd_dec;
                n_active = !upd_done;
                o_push   = 1'b1;
            end else begin
                n_active = 1'b0;
            end
        end
    end

    assign o_entry = '{cx: r_cx, cy: r_cy, x: r_x, y: r_y, done: upd_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_dec    <= '0;
        end else begin
            r_active <= n_active;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_dec    <= n_dec;
        end
    end
endmodule

// File: hdl/mcr_queue.sv
// short queue of octant points between front and back
// depends on mcr_pkg, midpoint_circle_rasterizer_unit_assert.svh
module mcr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mcr_pkg::t_step     i_data,
    input  logic               i_pop,
    output mcr_pkg::t_step     o_head,
    output mcr_pkg::t_q_status o_status
);
    import mcr_pkg::*;
    `include "midpoint_circle_rasterizer_unit_assert.svh"

    t_step                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    `MCR_ASSERT_RST(a_q_no_overflow, i_clk, i_rst_n, !(i_push && o_status.full && !i_pop), "queue push while full")
    `MCR_ASSERT_RST(a_q_count_up, i_clk, i_rst_n, i_push && !i_pop |=> r_count == $past(r_count) + QCNT_BITS'(1), "queue count did not follow push")
endmodule

// File: hdl/mcr_back.sv
// back end: expands each octant point into eight pixels, holds the origin
// depends on mcr_pkg, mcr_out_if, midpoint_circle_rasterizer_unit_assert.svh
module mcr_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [mcr_pkg::ORIGIN_BITS-1:0]  i_cfg_data,
    input  mcr_pkg::t_step                   i_head,
    input  logic                             i_q_empty,
    output logic                             o_pop,
    mcr_out_if.source                        o_pix
);
    import mcr_pkg::*;
    `include "midpoint_circle_rasterizer_unit_assert.svh"

    logic [ORIGIN_BITS-1:0]  r_origin_x;
    logic [ORIGIN_BITS-1:0]  r_origin_y;
    logic [PIX_IDX_BITS-1:0] r_k;
    logic                    r_ovalid;
    logic [PIXEL_BITS-1:0]   r_px;
    logic [PIXEL_BITS-1:0]   r_py;
    logic                    r_olast;
    logic                    r_odone;

    logic                    load;
    logic                    is_last;
    logic signed [STEP_BITS-1:0]  a;
    logic signed [STEP_BITS-1:0]  b;
    logic signed [PIXEL_BITS-1:0] a_ext;
    logic signed [PIXEL_BITS-1:0] b_ext;
    logic [PIXEL_BITS-1:0]   n_px;
    logic [PIXEL_BITS-1:0]   n_py;

    assign load    = !i_q_empty && (!r_ovalid || o_pix.ready);
    assign is_last = (r_k == PIX_IDX_BITS'(PIX_PER_STEP - 1));
    assign o_pop   = load && is_last;

    // k[2] swaps x and y, k[0] negates the x offset, k[1] the y offset
    always_comb begin
        a     = r_k[2] ? i_head.y : i_head.x;
        b     = r_k[2] ? i_head.x : i_head.y;
        a_ext = PIXEL_BITS'(a);
        b_ext = PIXEL_BITS'(b);
        n_px  = PIXEL_BITS'(i_head.cx) + (r_k[0] ? -a_ext : a_ext)
              + PIXEL_BITS'(r_origin_x);
        n_py  = PIXEL_BITS'(i_head.cy) + (r_k[1] ? -b_ext : b_ext)
              + PIXEL_BITS'(r_origin_y);
    end

    assign o_pix.valid        = r_ovalid;
    assign o_pix.pixel_x      = $signed(r_px);
    assign o_pix.pixel_y      = $signed(r_py);
    assign o_pix.last_of_step = r_olast;
    assign o_pix.circle_done  = r_odone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_X_RESET;
            r_origin_y <= ORIGIN_Y_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_k      <= r_k + PIX_IDX_BITS'(1);
                r_ovalid <= 1'b1;
            end else if (o_pix.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_olast <= is_last;
            r_odone <= is_last && i_head.done;
        end
    end

    `MCR_ASSERT_RST(a_done_on_last, i_clk, i_rst_n, r_ovalid && r_odone |-> r_olast, "done flag off the last pixel")
    `MCR_ASSERT_RST(a_mid_step_head, i_clk, i_rst_n, r_k != '0 |-> !i_q_empty, "partial step without queued point")
    `MCR_ASSERT_RST(a_pop_restarts, i_clk, i_rst_n, o_pop |=> r_k == '0 && r_ovalid && r_olast, "pixel index not restarted after pop")
endmodule

// File: hdl/midpoint_circle_rasterizer_unit.sv
// channel   dir  handshake     payload
// i_cmd     in   valid/ready   action, center_x, center_y, radius
// o_pix     out  valid/ready   pixel_x, pixel_y, last_of_step, circle_done
// cfg       in   write enable  i_cfg_index, i_cfg_data (origin_x, origin_y)
//
// commands are taken one per cycle while the two-entry point queue has room
// each step with a live point yields eight pixels, one per cycle from the
// back-end expander while the pixel output is not stalled
// start and idle steps emit nothing
// synchronous active-low reset; origin returns to 320, 240
// a stalled pixel output backs up the queue, then stops command intake
module midpoint_circle_rasterizer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mcr_in_if.sink                           i_cmd,
    mcr_out_if.source                        o_pix,
    input  logic                             i_cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [mcr_pkg::ORIGIN_BITS-1:0]  i_cfg_data
);
    import mcr_pkg::*;

    logic      push;
    logic      pop;
    t_step     entry;
    t_step     head;
    t_q_status q_status;

    mcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_entry  (entry)
    );

    mcr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .o_pix       (o_pix)
    );
endmodule
